FILE: hdl/msgpack_token_decoder_assert.svh
// ============================================================================
// Assertion macros for the token decoder
// Shared property forms used by the decoder modules.
// ============================================================================
`ifndef MSGPACK_TOKEN_DECODER_ASSERT_SVH
`define MSGPACK_TOKEN_DECODER_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define MTD_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// A condition that must hold on every clock edge outside reset.
`define MTD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

FILE: hdl/mtd_pkg.sv
// ============================================================================
// Token decoder package
// Token kinds, tag codes and the decoded-beat record shared by the modules.
// ============================================================================
package mtd_pkg;

    typedef enum logic [2:0] {
        K_NIL   = 3'd0,
        K_BOOL  = 3'd1,
        K_INT   = 3'd2,
        K_FLOAT = 3'd3,
        K_STR   = 3'd4,
        K_ARR   = 3'd5,
        K_MAP   = 3'd6,
        K_ERR   = 3'd7
    } t_kind;

    localparam logic [7:0] TAG_NIL     = 8'hc0;
    localparam logic [7:0] TAG_FALSE   = 8'hc2;
    localparam logic [7:0] TAG_TRUE    = 8'hc3;
    localparam logic [7:0] TAG_FLOAT32 = 8'hca;
    localparam logic [7:0] TAG_FLOAT64 = 8'hcb;
    localparam logic [7:0] TAG_UINT8   = 8'hcc;
    localparam logic [7:0] TAG_UINT16  = 8'hcd;
    localparam logic [7:0] TAG_UINT32  = 8'hce;
    localparam logic [7:0] TAG_UINT64  = 8'hcf;
    localparam logic [7:0] TAG_INT8    = 8'hd0;
    localparam logic [7:0] TAG_INT16   = 8'hd1;
    localparam logic [7:0] TAG_INT32   = 8'hd2;
    localparam logic [7:0] TAG_INT64   = 8'hd3;
    localparam logic [7:0] TAG_STR8    = 8'hd9;
    localparam logic [7:0] TAG_STR16   = 8'hda;
    localparam logic [7:0] TAG_STR32   = 8'hdb;
    localparam logic [7:0] TAG_BIN8    = 8'hc4;
    localparam logic [7:0] TAG_BIN16   = 8'hc5;
    localparam logic [7:0] TAG_BIN32   = 8'hc6;
    localparam logic [7:0] TAG_ARR16   = 8'hdc;
    localparam logic [7:0] TAG_ARR32   = 8'hdd;
    localparam logic [7:0] TAG_MAP16   = 8'hde;
    localparam logic [7:0] TAG_MAP32   = 8'hdf;

    // Operation the back end performs for one beat.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_EMIT  = 3'd1,
        OP_SHIFT = 3'd2,
        OP_SKIP  = 3'd3
    } t_op;

    // Classified beat passed from the front end to the back end.
    typedef struct packed {
        t_op         op;
        t_kind       kind;
        logic        bool_value;
        logic [4:0]  short_len;
        logic [7:0]  data_byte;
        logic [7:0]  tag_byte;
        logic [3:0]  operand_bytes;
        logic        eod;
        logic [31:0] payload_offset;
    } t_beat;

    // Number of big-endian operand bytes after a sized tag.
    function automatic logic [3:0] operand_count(input logic [7:0] tag);
        logic [3:0] cnt;
        begin
            case (tag)
                TAG_UINT8, TAG_INT8, TAG_STR8, TAG_BIN8: cnt = 4'd1;
                TAG_UINT16, TAG_INT16, TAG_STR16, TAG_BIN16,
                TAG_ARR16, TAG_MAP16: cnt = 4'd2;
                TAG_UINT32, TAG_INT32, TAG_STR32, TAG_BIN32,
                TAG_ARR32, TAG_MAP32, TAG_FLOAT32: cnt = 4'd4;
                TAG_UINT64, TAG_INT64, TAG_FLOAT64: cnt = 4'd8;
                default: cnt = 4'd0;
            endcase
            return cnt;
        end
    endfunction

    // Exact widening of a single to a double; subnormals are normalised.
    function automatic logic [63:0] widen_single(input logic [31:0] s);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  lz;
        logic [23:0] mn;
        logic [10:0] de;
        logic [63:0] res;
        begin
            e  = s[30:23];
            m  = s[22:0];
            lz = 5'd0;
            for (int i = 22; i >= 0; i--) begin
                if (m[i] && lz == 5'd0 && (m >> (i + 1)) == 23'd0) begin
                    lz = 5'(22 - i);
                end
            end
            mn = {1'b0, m} << (lz + 5'd1);
            if (e == 8'hff) begin
                res = {s[31], 11'h7ff, m, 29'd0};
                if (m != 23'd0) begin
                    res[51] = 1'b1;
                end
            end else if (e == 8'd0) begin
                if (m == 23'd0) begin
                    res = {s[31], 63'd0};
                end else begin
                    de  = 11'd896 - 11'(lz);
                    res = {s[31], de, mn[22:0], 29'd0};
                end
            end else begin
                de  = 11'(e) + 11'd896;
                res = {s[31], de, m, 29'd0};
            end
            return res;
        end
    endfunction

endpackage

FILE: hdl/mtd_stream_if.sv
// ============================================================================
// Stream channel
// Valid/ready channel carrying a payload of a given type.
// ============================================================================
interface mtd_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/mtd_front.sv
// ============================================================================
// Token decoder front end
// Tracks the phase and counters per byte and classifies each beat.
// ============================================================================
module mtd_front
    import mtd_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        o_push,
    output t_beat       o_beat,
    input  logic        i_full
);

    typedef enum logic [2:0] {
        ST_TAG  = 3'b001,
        ST_OPND = 3'b010,
        ST_SKIP = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [3:0]              r_pending, n_pending;
    logic [31:0]             r_skip, n_skip;
    logic [OFFSET_WIDTH-1:0] r_offset, n_offset;
    logic [7:0]              r_tag, n_tag;
    logic [23:0]             r_len_acc, n_len_acc;
    logic                    fire;
    logic [3:0]              cnt;
    logic [31:0]             str_len;
    t_beat                   beat;

    assign o_ready = !i_full;
    assign fire    = i_valid && !i_full;
    assign cnt     = operand_count(i_data_byte);
    // Full string length once the last header byte is in.
    assign str_len = {r_len_acc, i_data_byte};

    // Phase tracking and classification.
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_skip    = r_skip;
        n_tag     = r_tag;
        n_len_acc = r_len_acc;
        n_offset  = r_offset + 1'b1;
        beat      = '0;
        beat.data_byte      = i_data_byte;
        beat.tag_byte       = r_tag;
        beat.eod            = i_end_of_data;
        beat.payload_offset = 32'(n_offset);
        case (r_state)
            ST_OPND: begin
                beat.op   = OP_SHIFT;
                n_len_acc = {r_len_acc[15:0], i_data_byte};
                n_pending = r_pending - 4'd1;
                if (r_pending == 4'd1) begin
                    n_state = ST_TAG;
                    if ((r_tag == TAG_STR8 || r_tag == TAG_STR16 || r_tag == TAG_STR32 ||
                         r_tag == TAG_BIN8 || r_tag == TAG_BIN16 || r_tag == TAG_BIN32) &&
                        str_len != 32'd0 && !i_end_of_data) begin
                        n_state = ST_SKIP;
                        n_skip  = str_len;
                    end
                end
            end
            ST_SKIP: begin
                beat.op = OP_SKIP;
                // Flag a payload byte that is not the last one of the payload.
                beat.short_len = (r_skip != 32'd1) ? 5'd1 : 5'd0;
                n_skip  = r_skip - 32'd1;
                if (r_skip == 32'd1) begin
                    n_state = ST_TAG;
                end
            end
            default: begin
                beat.op   = OP_EMIT;
                n_state   = ST_TAG;
                beat.short_len = i_data_byte[4:0];
                if (i_data_byte <= 8'h7f || i_data_byte >= 8'he0) begin
                    beat.kind = K_INT;
                end else if (i_data_byte >= 8'ha0 && i_data_byte <= 8'hbf) begin
                    beat.kind = K_STR;
                    if (i_data_byte[4:0] != 5'd0 && !i_end_of_data) begin
                        n_state = ST_SKIP;
                        n_skip  = {27'd0, i_data_byte[4:0]};
                    end
                end else if (i_data_byte >= 8'h80 && i_data_byte <= 8'h8f) begin
                    beat.kind = K_MAP;
                end else if (i_data_byte >= 8'h90 && i_data_byte <= 8'h9f) begin
                    beat.kind = K_ARR;
                end else if (i_data_byte == TAG_NIL) begin
                    beat.kind = K_NIL;
                end else if (i_data_byte == TAG_FALSE || i_data_byte == TAG_TRUE) begin
                    beat.kind       = K_BOOL;
                    beat.bool_value = i_data_byte[0];
                end else if (cnt == 4'd0 || i_end_of_data) begin
                    beat.kind = K_ERR;
                end else begin
                    beat.op            = OP_NONE;
                    beat.tag_byte      = i_data_byte;
                    beat.operand_bytes = cnt;
                    n_state   = ST_OPND;
                    n_tag     = i_data_byte;
                    n_pending = cnt;
                    n_len_acc = '0;
                end
            end
        endcase
        if (i_end_of_data) begin
            n_state   = ST_TAG;
            n_pending = '0;
            n_skip    = '0;
            n_tag     = '0;
            n_offset  = '0;
        end
    end

    assign o_push = fire;
    assign o_beat = beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_TAG;
            r_pending <= '0;
            r_skip    <= '0;
            r_offset  <= '0;
            r_tag     <= '0;
            r_len_acc <= '0;
        end else if (fire) begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_skip    <= n_skip;
            r_offset  <= n_offset;
            r_tag     <= n_tag;
            r_len_acc <= n_len_acc;
        end
    end

endmodule

FILE: hdl/mtd_queue.sv
// ============================================================================
// Token decoder beat queue
// Four-entry FIFO that decouples the front end from the back end.
// ============================================================================
module mtd_queue
    import mtd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_beat i_beat,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_beat o_beat
);

    `include "msgpack_token_decoder_assert.svh"

    t_beat      r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;

    assign o_full  = (r_count == 3'd4);
    assign o_valid = (r_count != 3'd0);
    assign o_beat  = r_mem[r_rd];

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= r_count + 3'(i_push) - 3'(i_pop);
        end
    end

    `MTD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `MTD_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, !o_valid, !i_pop)
    `MTD_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= 3'd4)

endmodule

FILE: hdl/mtd_back.sv
// ============================================================================
// Token decoder back end
// Gathers operand bytes, builds tokens and holds them in an output register.
// ============================================================================
module mtd_back
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_pop,
    input  t_beat       i_beat,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [63:0] o_int_value,
    output logic        o_bool_value,
    output logic [63:0] o_float_bits,
    output logic [31:0] o_length,
    output logic [31:0] o_payload_offset
);

    `include "msgpack_token_decoder_assert.svh"

    logic [63:0] r_acc;
    logic [3:0]  r_pending;
    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [63:0] r_int, r_float;
    logic        r_bool;
    logic [31:0] r_len, r_poff;

    logic        can_take;
    logic [63:0] acc_next;
    logic        emit;
    logic [2:0]  e_kind;
    logic [63:0] e_int, e_float;
    logic        e_bool;
    logic [31:0] e_len, e_poff;
    logic        is_str;

    assign can_take = !r_out_valid || i_ready;
    assign o_pop    = i_valid && can_take;
    assign acc_next = {r_acc[55:0], i_beat.data_byte};
    assign is_str   = (i_beat.tag_byte == TAG_STR8 || i_beat.tag_byte == TAG_STR16 ||
                       i_beat.tag_byte == TAG_STR32 || i_beat.tag_byte == TAG_BIN8 ||
                       i_beat.tag_byte == TAG_BIN16 || i_beat.tag_byte == TAG_BIN32);

    // Token construction.
    always_comb begin
        emit    = 1'b0;
        e_kind  = K_NIL;
        e_int   = '0;
        e_float = '0;
        e_bool  = 1'b0;
        e_len   = '0;
        e_poff  = '0;
        case (i_beat.op)
            OP_EMIT: begin
                emit   = 1'b1;
                e_kind = i_beat.kind;
                case (i_beat.kind)
                    K_INT: e_int = {{56{i_beat.data_byte[7]}}, i_beat.data_byte};
                    K_BOOL: e_bool = i_beat.bool_value;
                    K_MAP, K_ARR: e_len = {28'd0, i_beat.short_len[3:0]};
                    K_STR: begin
                        e_poff = i_beat.payload_offset;
                        e_len  = {27'd0, i_beat.short_len};
                        if (i_beat.short_len != 5'd0 && i_beat.eod) begin
                            e_kind = K_ERR;
                            e_len  = '0;
                            e_poff = '0;
                        end
                    end
                    default: e_kind = i_beat.kind;
                endcase
            end
            OP_SHIFT: begin
                emit = (r_pending == 4'd1) || i_beat.eod;
                e_kind = K_ERR;
                if (r_pending == 4'd1) begin
                    case (i_beat.tag_byte)
                        TAG_UINT8, TAG_UINT16, TAG_UINT32, TAG_UINT64: begin
                            e_kind = K_INT;
                            e_int  = acc_next;
                        end
                        TAG_INT8: begin
                            e_kind = K_INT;
                            e_int  = {{56{acc_next[7]}}, acc_next[7:0]};
                        end
                        TAG_INT16: begin
                            e_kind = K_INT;
                            e_int  = {{48{acc_next[15]}}, acc_next[15:0]};
                        end
                        TAG_INT32: begin
                            e_kind = K_INT;
                            e_int  = {{32{acc_next[31]}}, acc_next[31:0]};
                        end
                        TAG_INT64: begin
                            e_kind = K_INT;
                            e_int  = acc_next;
                        end
                        TAG_FLOAT32: begin
                            e_kind  = K_FLOAT;
                            e_float = widen_single(acc_next[31:0]);
                        end
                        TAG_FLOAT64: begin
                            e_kind  = K_FLOAT;
                            e_float = acc_next;
                        end
                        TAG_ARR16, TAG_ARR32: begin
                            e_kind = K_ARR;
                            e_len  = acc_next[31:0];
                        end
                        TAG_MAP16, TAG_MAP32: begin
                            e_kind = K_MAP;
                            e_len  = acc_next[31:0];
                        end
                        default: begin
                            if (is_str && (acc_next[31:0] == 32'd0 || !i_beat.eod)) begin
                                e_kind = K_STR;
                                e_len  = acc_next[31:0];
                                e_poff = i_beat.payload_offset;
                            end
                        end
                    endcase
                end
            end
            OP_SKIP: begin
                // The front end only forwards a skip beat; error on early end.
                emit   = 1'b0;
                e_kind = K_ERR;
            end
            default: emit = 1'b0;
        endcase
    end

    // The skip error needs the remaining count, which the front end folds in.
    logic skip_err;
    assign skip_err = (i_beat.op == OP_SKIP) && i_beat.eod && (i_beat.short_len == 5'd1);

    // Accumulator, pending count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_beat.op == OP_NONE) begin
                    r_acc     <= '0;
                    r_pending <= i_beat.operand_bytes;
                end else if (i_beat.op == OP_SHIFT) begin
                    r_acc     <= acc_next;
                    r_pending <= r_pending - 4'd1;
                end
                if (emit || skip_err) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (emit || skip_err)) begin
            r_kind  <= e_kind;
            r_int   <= e_int;
            r_float <= e_float;
            r_bool  <= e_bool;
            r_len   <= e_len;
            r_poff  <= e_poff;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_int_value      = r_int;
    assign o_bool_value     = r_bool;
    assign o_float_bits     = r_float;
    assign o_length         = r_len;
    assign o_payload_offset = r_poff;

    `MTD_ASSERT_IMPL(a_hold_out, i_clk, i_rst_n, r_out_valid && !i_ready, ##1 r_out_valid)
    `MTD_ASSERT_IMPL(a_shift_pending, i_clk, i_rst_n,
                     o_pop && i_beat.op == OP_SHIFT, r_pending != 4'd0)

endmodule

FILE: hdl/msgpack_token_decoder.sv
// A token passes through the beat queue and then the back end's output register.
// Throughput: one byte per cycle while the four-entry beat queue has room; a stalled output register fills it.
// Payload bytes and operand bytes before the last emit no token unless the data ends early.
// Reset: synchronous active-low i_rst_n clears phase, counters, offset and queue.
// An end-of-data beat returns the front end to its tag phase and clears its counters, tag and offset.
// ============================================================================
// MessagePack token decoder
// Decodes a MessagePack byte stream into one token per complete tag.
// ============================================================================
module msgpack_token_decoder
    import mtd_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mtd_stream_if.sink   i_in,
    mtd_stream_if.source o_out
);

    logic  push, full, q_valid, pop;
    t_beat f_beat, q_beat;

    mtd_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_data_byte   (i_in.payload.data_byte),
        .i_end_of_data (i_in.payload.end_of_data),
        .o_push        (push),
        .o_beat        (f_beat),
        .i_full        (full)
    );

    mtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (f_beat),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_beat  (q_beat)
    );

    mtd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .o_pop            (pop),
        .i_beat           (q_beat),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_kind           (o_out.payload.kind),
        .o_int_value      (o_out.payload.int_value),
        .o_bool_value     (o_out.payload.bool_value),
        .o_float_bits     (o_out.payload.float_bits),
        .o_length         (o_out.payload.length),
        .o_payload_offset (o_out.payload.payload_offset)
    );

endmodule
